// ===== src/arps_pkg.sv =====
// Shared constants, types and helper functions of the arpeggiator step scheduler.
package arps_pkg;

    localparam int POOL_DEPTH     = 32;
    localparam int QUEUE_CAPACITY = 64;

    localparam int POOL_AW  = $clog2(POOL_DEPTH);
    localparam int COUNT_W  = $clog2(POOL_DEPTH + 1);
    localparam int IX_W     = COUNT_W + 1;

    localparam int APB_AW   = 5;

    // shared divider: 32-bit dividend, two quotient bits per cycle
    localparam int DVND_W    = 32;
    localparam int DVSR_W    = 12;
    localparam int DIV_STEPS = DVND_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int STEP_W = 21;   // longest step: 60e6 / 30 us
    localparam int PROD_W = 28;   // step * 100

    localparam logic [DVND_W-1:0] QUARTER_US = 32'd60000000;
    localparam logic [DVSR_W-1:0] GATE_SCALE = 12'd100;
    localparam int PATTERN_LEN = 6;
    localparam int BPM_MIN  = 30;
    localparam int BPM_MAX  = 300;
    localparam int GATE_MIN = 1;
    localparam int GATE_MAX = 100;

    typedef enum logic [1:0] {
        MODE_STEP   = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_POOL_EMPTY = 2'd1,
        STAT_SCHED_FULL = 2'd2,
        STAT_POOL_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DIR_UP     = 2'd0,
        DIR_DOWN   = 2'd1,
        DIR_UPDOWN = 2'd2,
        DIR_RANDOM = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        DIV_QUARTER        = 3'd0,
        DIV_EIGHTH         = 3'd1,
        DIV_EIGHTH_TRIP    = 3'd2,
        DIV_SIXTEENTH      = 3'd3,
        DIV_SIXTEENTH_TRIP = 3'd4,
        DIV_THIRTY_SECOND  = 3'd5
    } division_t;

    typedef enum logic [2:0] {
        REG_TEMPO    = 3'd0,
        REG_DIVISION = 3'd1,
        REG_GATE     = 3'd2,
        REG_DIR      = 3'd3,
        REG_PATTERN  = 3'd4,
        REG_SEED     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] tempo_bpm;
        logic [2:0]  note_division;
        logic [7:0]  gate_pct;
        logic [1:0]  step_direction;
        logic        pattern_mode;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic [31:0] value;
    } seed_load_t;

    typedef struct packed {
        logic              start;
        logic [DVND_W-1:0] dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DVND_W-1:0] quotient;
        logic [DVSR_W-1:0] remainder;
    } div_resp_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_note_on;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [7:0]  owner;
        logic [63:0] time_us;
        logic        last;
    } result_t;

    // quarter-note divisor per division code; unknown codes act as sixteenth
    function automatic logic [3:0] div_factor(input logic [2:0] code);
        logic [3:0] f;
        case (code)
            DIV_QUARTER:        f = 4'd1;
            DIV_EIGHTH:         f = 4'd2;
            DIV_EIGHTH_TRIP:    f = 4'd3;
            DIV_SIXTEENTH:      f = 4'd4;
            DIV_SIXTEENTH_TRIP: f = 4'd6;
            DIV_THIRTY_SECOND:  f = 4'd8;
            default:            f = 4'd4;
        endcase
        return f;
    endfunction

    // fixed pattern 0,1,3,2,1,2
    function automatic logic [1:0] pattern_at(input logic [2:0] pos);
        logic [1:0] p;
        case (pos)
            3'd0:    p = 2'd0;
            3'd1:    p = 2'd1;
            3'd2:    p = 2'd3;
            3'd3:    p = 2'd2;
            3'd4:    p = 2'd1;
            3'd5:    p = 2'd2;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] v;
        v = s;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

endpackage

// ===== src/arps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module arps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/arps_div.sv =====
// Shared iterative restoring divider, two quotient bits per cycle.
module arps_div import arps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  div_req_t  req,
    output div_resp_t resp
);

    logic [DVND_W-1:0]    quo_reg, quo_next;
    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [DVSR_W-1:0]    dvsr_reg, dvsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DVSR_W:0]   t1, t2;
    logic              ge1, ge2;
    logic [DVSR_W-1:0] r1, r2;

    always_comb begin
        t1  = {rem_reg, quo_reg[DVND_W-1]};
        ge1 = t1 >= {1'b0, dvsr_reg};
        r1  = ge1 ? DVSR_W'(t1 - {1'b0, dvsr_reg}) : t1[DVSR_W-1:0];
        t2  = {r1, quo_reg[DVND_W-2]};
        ge2 = t2 >= {1'b0, dvsr_reg};
        r2  = ge2 ? DVSR_W'(t2 - {1'b0, dvsr_reg}) : t2[DVSR_W-1:0];

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVND_W-3:0], ge1, ge2};
            rem_next = r2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign resp.busy      = busy_reg;
    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg;

endmodule

// ===== src/arps_seq.sv =====
// Sequencer: pool bookkeeping, note pick, step timing and result register.
module arps_seq import arps_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  seed_load_t         seed,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [31:0]        s_step_number,
    input  logic [63:0]        s_start_time_us,
    input  logic [3:0]         s_midi_channel,
    input  logic [6:0]         s_note_velocity,
    input  logic [7:0]         s_owner_tag,
    input  logic [6:0]         s_queue_used,
    input  logic [6:0]         s_pool_note,
    output logic               m_valid,
    output result_t            m_result,
    input  logic               m_ready,
    output div_req_t           div_req,
    input  div_resp_t          div_resp,
    output logic               ram_we,
    output logic [POOL_AW-1:0] ram_waddr,
    output logic [6:0]         ram_wdata,
    output logic [POOL_AW-1:0] ram_raddr,
    input  logic [6:0]         ram_rdata
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_IDX  = 8'b0000_0010,
        S_LEN  = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_GATE = 8'b0001_0000,
        S_ON   = 8'b0010_0000,
        S_OFF  = 8'b0100_0000,
        S_STAT = 8'b1000_0000
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] pool_count_reg, pool_count_next;
    logic [31:0]        rnd_reg, rnd_next;
    logic               m_valid_reg, m_valid_next;
    result_t            m_result_reg, m_result_next;

    logic [3:0]         chan_reg, chan_next;
    logic [6:0]         vel_reg, vel_next;
    logic [7:0]         owner_reg, owner_next;
    logic [63:0]        start_reg, start_next;
    logic [POOL_AW-1:0] idx_reg, idx_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [63:0]        off_reg, off_next;
    logic [1:0]         status_reg, status_next;

    logic               accept;
    logic               out_free;
    logic [31:0]        rnd_new;
    logic               sched_full;
    logic [IX_W-1:0]    cnt_x, cyc_x, rem_x, ix;
    logic [1:0]         pat;
    logic [8:0]         bpm_cl;
    logic [6:0]         gate_cl;
    logic [12:0]        len_dvsr;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rnd_new  = xorshift32(rnd_reg);
    assign sched_full = (32'(s_queue_used) + 32'd2) > 32'(QUEUE_CAPACITY);

    // note index from the divider remainder
    always_comb begin
        cnt_x = IX_W'(pool_count_reg);
        cyc_x = IX_W'((cnt_x << 1) - IX_W'(2));
        rem_x = div_resp.remainder[IX_W-1:0];
        pat   = pattern_at(div_resp.remainder[2:0]);
        if (pool_count_reg < COUNT_W'(2)) begin
            ix = '0;
        end else if (cfg.pattern_mode) begin
            if (pool_count_reg == COUNT_W'(2)) begin
                ix = IX_W'(pat[0]);
            end else if (pool_count_reg == COUNT_W'(3) && pat == 2'd3) begin
                ix = '0;
            end else begin
                ix = IX_W'(pat);
            end
        end else begin
            case (dir_t'(cfg.step_direction))
                DIR_DOWN:   ix = cnt_x - IX_W'(1) - rem_x;
                DIR_UPDOWN: ix = (rem_x < cnt_x) ? rem_x : cyc_x - rem_x;
                default:    ix = rem_x;
            endcase
        end
    end

    always_comb begin
        if (cfg.tempo_bpm < 16'(BPM_MIN)) begin
            bpm_cl = 9'(BPM_MIN);
        end else if (cfg.tempo_bpm > 16'(BPM_MAX)) begin
            bpm_cl = 9'(BPM_MAX);
        end else begin
            bpm_cl = cfg.tempo_bpm[8:0];
        end
        if (cfg.gate_pct < 8'(GATE_MIN)) begin
            gate_cl = 7'(GATE_MIN);
        end else if (cfg.gate_pct > 8'(GATE_MAX)) begin
            gate_cl = 7'(GATE_MAX);
        end else begin
            gate_cl = cfg.gate_pct[6:0];
        end
        // quarter / factor folded into one division by bpm * factor
        len_dvsr = {4'b0, bpm_cl} * {9'b0, div_factor(cfg.note_division)};
    end

    always_comb begin
        state_next      = state_reg;
        pool_count_next = pool_count_reg;
        rnd_next        = rnd_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_result_next   = m_result_reg;
        chan_next       = chan_reg;
        vel_next        = vel_reg;
        owner_next      = owner_reg;
        start_next      = start_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        off_next        = off_reg;
        status_next     = status_reg;
        div_req         = '0;
        ram_we          = 1'b0;

        if (seed.load) begin
            rnd_next = (seed.value == 32'd0) ? 32'd1 : seed.value;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (mode_t'(s_mode))
                        MODE_APPEND: begin
                            if (pool_count_reg < COUNT_W'(POOL_DEPTH)) begin
                                ram_we          = 1'b1;
                                pool_count_next = pool_count_reg + 1'b1;
                                status_next     = STAT_OK;
                            end else begin
                                status_next = STAT_POOL_FULL;
                            end
                            state_next = S_STAT;
                        end
                        MODE_CLEAR: begin
                            pool_count_next = '0;
                            status_next     = STAT_OK;
                            state_next      = S_STAT;
                        end
                        MODE_STEP: begin
                            chan_next  = s_midi_channel;
                            vel_next   = s_note_velocity;
                            owner_next = s_owner_tag;
                            start_next = s_start_time_us;
                            if (pool_count_reg == '0) begin
                                status_next = STAT_POOL_EMPTY;
                                state_next  = S_STAT;
                            end else if (sched_full) begin
                                status_next = STAT_SCHED_FULL;
                                state_next  = S_STAT;
                            end else begin
                                // generator moves even when the pattern overrides
                                if (cfg.step_direction == DIR_RANDOM &&
                                    pool_count_reg >= COUNT_W'(2)) begin
                                    rnd_next = rnd_new;
                                end
                                div_req.start = 1'b1;
                                if (cfg.pattern_mode) begin
                                    div_req.dividend = s_step_number;
                                    div_req.divisor  = DVSR_W'(PATTERN_LEN);
                                end else if (cfg.step_direction == DIR_RANDOM) begin
                                    div_req.dividend = rnd_new;
                                    div_req.divisor  = DVSR_W'(cnt_x);
                                end else if (cfg.step_direction == DIR_UPDOWN) begin
                                    div_req.dividend = s_step_number;
                                    div_req.divisor  = DVSR_W'(cyc_x);
                                end else begin
                                    div_req.dividend = s_step_number;
                                    div_req.divisor  = DVSR_W'(cnt_x);
                                end
                                state_next = S_IDX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_IDX: begin
                if (div_resp.done) begin
                    idx_next         = ix[POOL_AW-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = QUARTER_US;
                    div_req.divisor  = len_dvsr[DVSR_W-1:0];
                    state_next       = S_LEN;
                end
            end
            S_LEN: begin
                if (div_resp.done) begin
                    prod_next  = PROD_W'({7'b0, div_resp.quotient[STEP_W-1:0]} *
                                         {21'b0, gate_cl});
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVND_W'(prod_reg);
                div_req.divisor  = GATE_SCALE;
                state_next       = S_GATE;
            end
            S_GATE: begin
                if (div_resp.done) begin
                    off_next   = start_reg + 64'(div_resp.quotient);
                    state_next = S_ON;
                end
            end
            S_ON: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_result_next = '{status: STAT_OK, is_note_on: 1'b1,
                                      channel: chan_reg, note: ram_rdata,
                                      velocity: vel_reg, owner: owner_reg,
                                      time_us: start_reg, last: 1'b0};
                    state_next    = S_OFF;
                end
            end
            S_OFF: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_result_next = '{status: STAT_OK, is_note_on: 1'b0,
                                      channel: chan_reg, note: m_result_reg.note,
                                      velocity: 7'd0, owner: owner_reg,
                                      time_us: off_reg, last: 1'b1};
                    state_next    = S_IDLE;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_result_next        = '0;
                    m_result_next.status = status_reg;
                    m_result_next.last   = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pool_count_reg <= '0;
            rnd_reg        <= 32'd1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pool_count_reg <= pool_count_next;
            rnd_reg        <= rnd_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_result_reg <= m_result_next;
        chan_reg     <= chan_next;
        vel_reg      <= vel_next;
        owner_reg    <= owner_next;
        start_reg    <= start_next;
        idx_reg      <= idx_next;
        prod_reg     <= prod_next;
        off_reg      <= off_next;
        status_reg   <= status_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;
    assign ram_waddr = pool_count_reg[POOL_AW-1:0];
    assign ram_wdata = s_pool_note;
    assign ram_raddr = idx_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pool_count_reg <= COUNT_W'(POOL_DEPTH))
        else $error("pool count beyond depth");

    a_on_then_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_result_reg.last) |-> (state_reg == S_OFF))
        else $error("note-on pending without note-off in flight");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_CLEAR) |=> (pool_count_reg == '0))
        else $error("clear did not empty the pool");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_resp.busy)
        else $error("divider still running while idle");

endmodule

// ===== src/arpeggiator_step_scheduler.sv =====
// Top level: APB register file, note pool RAM, shared divider and sequencer.
//
// An append or clear transfer has its single result registered from the
// status state once the output register is free, and the next transfer
// can be accepted in the same cycle as that result becomes valid. A step
// transfer runs three passes through one shared divider that retires two
// quotient bits per cycle: the index modulo, 60000000 / (bpm * division
// factor) for the step length, and the gated product divided by 100, with
// a 21x7 multiply before the last pass and a 64-bit add after it. The
// note-on is registered once the last pass is done and the output register
// is free, and the note-off follows once the note-on is taken; output
// stalls hold the sequencer. s_ready is high only while the sequencer is
// idle. A result waits in an output register and does not hold up the next
// item. Pool entries live in a RAM with no reset and need no clearing pass;
// only entries below the fill count are ever read. Configuration is to be
// written over APB only while idle; the block does not enforce this. A seed
// write also reloads the random generator, zero loading one.
module arpeggiator_step_scheduler import arps_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [31:0]       s_step_number,
    input  logic [63:0]       s_start_time_us,
    input  logic [3:0]        s_midi_channel,
    input  logic [6:0]        s_note_velocity,
    input  logic [7:0]        s_owner_tag,
    input  logic [6:0]        s_queue_used,
    input  logic [6:0]        s_pool_note,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic              m_is_note_on,
    output logic [3:0]        m_out_channel,
    output logic [6:0]        m_out_note,
    output logic [6:0]        m_out_velocity,
    output logic [7:0]        m_out_owner,
    output logic [63:0]       m_event_time_us,
    output logic              m_last
);

    logic [15:0] tempo_bpm_reg;
    logic [2:0]  note_division_reg;
    logic [7:0]  gate_pct_reg;
    logic [1:0]  step_direction_reg;
    logic        pattern_mode_reg;
    logic [31:0] random_seed_reg;

    logic        wr;
    reg_idx_t    widx;
    cfg_t        cfg;
    seed_load_t  seed;
    div_req_t    div_req;
    div_resp_t   div_resp;
    result_t     result;

    logic               ram_we;
    logic [POOL_AW-1:0] ram_waddr, ram_raddr;
    logic [6:0]         ram_wdata, ram_rdata;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tempo_bpm_reg      <= 16'd120;
            note_division_reg  <= DIV_SIXTEENTH;
            gate_pct_reg       <= 8'd50;
            step_direction_reg <= DIR_UP;
            pattern_mode_reg   <= 1'b0;
            random_seed_reg    <= 32'd1;
        end else if (wr) begin
            case (widx)
                REG_TEMPO:    tempo_bpm_reg      <= pwdata[15:0];
                REG_DIVISION: note_division_reg  <= pwdata[2:0];
                REG_GATE:     gate_pct_reg       <= pwdata[7:0];
                REG_DIR:      step_direction_reg <= pwdata[1:0];
                REG_PATTERN:  pattern_mode_reg   <= pwdata[0];
                REG_SEED:     random_seed_reg    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_TEMPO:    prdata = {16'd0, tempo_bpm_reg};
            REG_DIVISION: prdata = {29'd0, note_division_reg};
            REG_GATE:     prdata = {24'd0, gate_pct_reg};
            REG_DIR:      prdata = {30'd0, step_direction_reg};
            REG_PATTERN:  prdata = {31'd0, pattern_mode_reg};
            REG_SEED:     prdata = random_seed_reg;
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.tempo_bpm      = tempo_bpm_reg;
    assign cfg.note_division  = note_division_reg;
    assign cfg.gate_pct       = gate_pct_reg;
    assign cfg.step_direction = step_direction_reg;
    assign cfg.pattern_mode   = pattern_mode_reg;
    assign seed.load          = wr && (widx == REG_SEED);
    assign seed.value         = pwdata;

    arps_ram #(
        .WIDTH (7),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    arps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    arps_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .seed            (seed),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_step_number   (s_step_number),
        .s_start_time_us (s_start_time_us),
        .s_midi_channel  (s_midi_channel),
        .s_note_velocity (s_note_velocity),
        .s_owner_tag     (s_owner_tag),
        .s_queue_used    (s_queue_used),
        .s_pool_note     (s_pool_note),
        .m_valid         (m_valid),
        .m_result        (result),
        .m_ready         (m_ready),
        .div_req         (div_req),
        .div_resp        (div_resp),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata)
    );

    assign m_status        = result.status;
    assign m_is_note_on    = result.is_note_on;
    assign m_out_channel   = result.channel;
    assign m_out_note      = result.note;
    assign m_out_velocity  = result.velocity;
    assign m_out_owner     = result.owner;
    assign m_event_time_us = result.time_us;
    assign m_last          = result.last;

endmodule
